// ===== design/smce_pkg.sv =====
// Shared constants, register indexes and the exp table for the softmax loss block.
package smce_pkg;

  // Row length limit (default of the top-level parameter)
  localparam int unsigned MAX_CLASSES_DEF = 64;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [20:0] LOSS_MAX  = 21'd2097151;

  // Configuration register indexes
  localparam logic CFG_BATCH_SIZE  = 1'b0;
  localparam logic CFG_TARGET_MODE = 1'b1;

  // Widths of the datapath
  localparam int unsigned SUM_W = 23;   // sum of up to 64 values of at most 2^16
  localparam int unsigned DIV_W = 33;   // dividend and quotient of the shared divider
  localparam int unsigned DEN_W = 24;   // divisor of the shared divider

  // 2^(-i/32) in Q1.16, i = 0..32
  function automatic logic [16:0] pow2_tab(input logic [5:0] i);
    logic [16:0] v;
    case (i)
      6'd0:  v = 17'd65536;  6'd1:  v = 17'd64132;  6'd2:  v = 17'd62757;
      6'd3:  v = 17'd61413;  6'd4:  v = 17'd60097;  6'd5:  v = 17'd58809;
      6'd6:  v = 17'd57549;  6'd7:  v = 17'd56316;  6'd8:  v = 17'd55109;
      6'd9:  v = 17'd53928;  6'd10: v = 17'd52773;  6'd11: v = 17'd51642;
      6'd12: v = 17'd50535;  6'd13: v = 17'd49452;  6'd14: v = 17'd48393;
      6'd15: v = 17'd47356;  6'd16: v = 17'd46341;  6'd17: v = 17'd45348;
      6'd18: v = 17'd44376;  6'd19: v = 17'd43425;  6'd20: v = 17'd42495;
      6'd21: v = 17'd41584;  6'd22: v = 17'd40693;  6'd23: v = 17'd39821;
      6'd24: v = 17'd38968;  6'd25: v = 17'd38133;  6'd26: v = 17'd37316;
      6'd27: v = 17'd36516;  6'd28: v = 17'd35734;  6'd29: v = 17'd34968;
      6'd30: v = 17'd34219;  6'd31: v = 17'd33486;  6'd32: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== design/smce_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module smce_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smce_pkg::DIV_W-1:0] num_i,
  input  logic [smce_pkg::DEN_W-1:0] den_i,
  output logic [smce_pkg::DIV_W-1:0] quo_o,
  output logic                       done_o
);
  import smce_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W-1:0] trial;
  logic             fits;

  // trial remainder: shift in next dividend bit
  assign trial = {rem_q[DEN_W-2:0], quo_q[DIV_W-1]};
  assign fits  = (trial >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - den_q) : trial;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than one cycle");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && den_q != '0) |-> rem_q < den_q)
    else $error("divider remainder out of range");
endmodule

// ===== design/smce_ln.sv =====
// Iterative -ln(p) for Q1.16 p: MSB position plus 16 fraction bits by squaring.
module smce_ln (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] p_i,
  output logic [19:0] nl_o,
  output logic        done_o
);
  import smce_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SQ   = 3'd1;
  localparam logic [2:0] L_ADJ  = 3'd2;
  localparam logic [2:0] L_FIN  = 3'd3;
  localparam logic [2:0] L_OUT  = 3'd4;

  logic [2:0]  st_q;
  logic [30:0] x_q;
  logic [61:0] sq_q;
  logic [15:0] frac_q;
  logic [3:0]  n_q;
  logic [4:0]  k_q;
  logic [36:0] mul_q;
  logic [16:0] p_eff;
  logic [4:0]  k_new;
  logic [46:0] x_sh;
  logic [31:0] y;
  logic [20:0] v;

  // floor at one LSB and find MSB
  always_comb begin
    p_eff = (p_i == '0) ? 17'd1 : p_i;
    k_new = '0;
    for (int b = 1; b < 17; b++) begin
      if (p_eff[b]) k_new = 5'(b);
    end
    x_sh = 47'(p_eff) << (5'd30 - k_new);
  end

  assign y = sq_q[61:30];
  assign v = {5'd16 - k_q, 16'd0} - {5'd0, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
      n_q  <= '0;
    end else begin
      case (st_q)
        L_IDLE: if (start_i) begin
          st_q <= L_SQ;
          n_q  <= '0;
        end
        L_SQ:  st_q <= L_ADJ;
        L_ADJ: begin
          n_q  <= n_q + 1'b1;
          st_q <= (n_q == 4'd15) ? L_FIN : L_SQ;
        end
        L_FIN:   st_q <= L_OUT;
        L_OUT:   st_q <= L_IDLE;
        default: st_q <= L_IDLE;
      endcase
    end
  end

  // squaring datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: if (start_i) begin
        x_q    <= x_sh[30:0];
        k_q    <= k_new;
        frac_q <= '0;
      end
      L_SQ: sq_q <= 62'(x_q) * 62'(x_q);
      L_ADJ: begin
        if (y[31]) begin
          x_q    <= y[31:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          x_q    <= y[30:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      L_FIN:   mul_q <= 37'(v) * 37'(LN2_Q16);
      default: ;
    endcase
  end

  assign nl_o   = mul_q[35:16];
  assign done_o = (st_q == L_OUT);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == L_IDLE) else $error("ln unit started while busy");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == L_SQ) |-> x_q[30]) else $error("ln operand not normalized");
  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == L_FIN) |=> done_o) else $error("ln result not presented");
endmodule

// ===== design/softmax_cross_entropy_loss_grad.sv =====
// Softmax cross-entropy loss and gradient: row memories, sequencer and output register.
// A row of up to MAX_CLASSES logits is taken one word per cycle into a row memory while
// the maximum is tracked; the word marked by tlast closes the row. The block then makes
// three passes over the c stored classes using one shared divider and an iterative ln
// unit: an exp pass, a normalize and loss pass (with an ln step for each class whose
// -ln(p) is needed: the labeled class, or every class in soft mode), a batch mean
// division, and a gradient pass that presents one output word per class, the last
// one with tlast. The shared divider sets the pace, and no input is taken until the
// last gradient word is in the output register. Entries of the memories are only read
// after being written in the same row.
module softmax_cross_entropy_loss_grad #(
  parameter int unsigned MAX_CLASSES = smce_pkg::MAX_CLASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // logit[15:0], soft_target[32:16], class_label[38:33], zero pad[39]
  input  logic [39:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // row_end
  // output words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // class_index[5:0], gradient[23:6], row_loss[44:24], batch_loss[65:45],
  // batch_done[66], label_bad[67], zero pad[71:68]
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // row_last
);
  import smce_pkg::*;

  localparam int unsigned AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned CW = $clog2(MAX_CLASSES + 1);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_E_RD  = 4'd1;
  localparam logic [3:0] ST_E_MUL = 4'd2;
  localparam logic [3:0] ST_E_INT = 4'd3;
  localparam logic [3:0] ST_E_WR  = 4'd4;
  localparam logic [3:0] ST_P_RD  = 4'd5;
  localparam logic [3:0] ST_P_DIV = 4'd6;
  localparam logic [3:0] ST_P_DW  = 4'd7;
  localparam logic [3:0] ST_P_LW  = 4'd8;
  localparam logic [3:0] ST_P_ACC = 4'd9;
  localparam logic [3:0] ST_B_SUM = 4'd10;
  localparam logic [3:0] ST_B_DIV = 4'd11;
  localparam logic [3:0] ST_B_DW  = 4'd12;
  localparam logic [3:0] ST_G_RD  = 4'd13;
  localparam logic [3:0] ST_G_DIV = 4'd14;
  localparam logic [3:0] ST_G_DW  = 4'd15;

  // control state
  logic [3:0]        state_q;
  logic              gout_q;       // gradient word waiting for the output register
  logic [15:0]       bs_q;
  logic              mode_q;
  logic [CW-1:0]     cnt_q, j_q;
  logic signed [15:0] max_q;
  logic [5:0]        label_q;
  logic              soft_q;
  logic [SUM_W-1:0]  sum_q;
  logic [31:0]       acc_q, loss_sum_q;
  logic [15:0]       rows_q;
  logic [20:0]       rl_q, bl_q;
  logic              done_q, bad_q;
  logic              ov_q;

  // datapath registers
  logic [32:0]       prod_q;
  logic [8:0]        k_q;
  logic [16:0]       base_q;
  logic [21:0]       ip_q;
  logic [36:0]       lp_q;
  logic [16:0]       tgl_q;
  logic              neg_q;
  logic [17:0]       g_q;
  logic [71:0]       odata_q;
  logic              olast_out_q;

  // memories
  logic [32:0] row_mem [MAX_CLASSES];
  logic [16:0] work_mem [MAX_CLASSES];
  logic [32:0] row_rd_q;
  logic [16:0] work_rd_q;

  // input word fields
  logic signed [15:0] in_logit;
  logic [16:0]        in_tgt;
  logic               in_acc, out_acc;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      wr_addr;
  logic               row_we, work_we, rd_en;
  logic [16:0]        work_wd;

  // exp stage signals
  logic [16:0] tdiff;
  logic [24:0] u;
  logic [16:0] m_val, ex_val;
  logic [16:0] tab_lo, tab_hi;

  // shared units
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             ln_start, ln_done;
  logic [19:0]      ln_val;

  // misc
  logic [15:0] bs_eff;
  logic        last_j, need_ln, out_load;
  logic [16:0] tg_row, tg_grad;
  logic [17:0] dval;
  logic [16:0] dabs;
  logic [32:0] ls_sum;
  logic [20:0] rl_new;

  assign in_logit = s_axis_tdata_i[15:0];
  assign in_tgt   = (s_axis_tdata_i[32:16] > ONE_Q16) ? ONE_Q16 : s_axis_tdata_i[32:16];
  assign s_axis_tready_o = (state_q == ST_LOAD) && !gout_q;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign addr     = j_q[AW-1:0];
  assign wr_addr  = cnt_q[AW-1:0];
  assign last_j   = (j_q + 1'b1 == cnt_q);
  assign bs_eff   = (bs_q == '0) ? 16'd1 : bs_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= 16'd1;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BATCH_SIZE:  bs_q   <= cfg_wdata_i;
        CFG_TARGET_MODE: mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // memory ports: no read and write of one entry overlap in this sequence
  assign row_we  = in_acc && (cnt_q < CW'(MAX_CLASSES));
  assign rd_en   = (state_q == ST_E_RD) || (state_q == ST_P_RD) || (state_q == ST_G_RD);
  assign work_we = (state_q == ST_E_WR) || ((state_q == ST_P_DW) && div_done);
  assign work_wd = (state_q == ST_E_WR) ? ex_val : div_quo[16:0];

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[wr_addr] <= {in_tgt, in_logit};
    if (rd_en)  row_rd_q <= row_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[addr] <= work_wd;
    if (rd_en)   work_rd_q <= work_mem[addr];
  end

  // exp(-(max - logit)) pieces
  assign tdiff  = {max_q[15], max_q} - {row_rd_q[15], row_rd_q[15:0]};
  assign u      = prod_q[32:8];
  assign tab_lo = pow2_tab({1'b0, u[15:11]});
  assign tab_hi = pow2_tab(6'({1'b0, u[15:11]} + 6'd1));
  assign m_val  = base_q - 17'(ip_q >> 11);
  assign ex_val = (k_q >= 9'd32) ? 17'd0 : (m_val >> k_q[4:0]);

  // loss and gradient target selection
  assign tg_row  = row_rd_q[32:16];
  assign need_ln = soft_q || ({1'b0, label_q} == 7'(j_q));
  assign tg_grad = soft_q ? tg_row :
                   (({1'b0, label_q} == 7'(j_q)) && !bad_q) ? ONE_Q16 : 17'd0;
  assign dval    = {1'b0, work_rd_q} - {1'b0, tg_grad};
  assign dabs    = dval[17] ? 17'(-dval) : dval[16:0];

  // batch accumulation
  assign rl_new = (acc_q > 32'(LOSS_MAX)) ? LOSS_MAX : acc_q[20:0];
  assign ls_sum = {1'b0, loss_sum_q} + 33'(rl_new);

  // shared divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 24'd1;
    case (state_q)
      ST_P_DIV: begin
        div_start = 1'b1;
        div_num   = {work_rd_q, 16'd0};
        div_den   = DEN_W'(sum_q);
      end
      ST_B_DIV: begin
        div_start = 1'b1;
        div_num   = 33'(loss_sum_q);
        div_den   = (rows_q == '0) ? 24'd1 : 24'(rows_q);
      end
      ST_G_DIV: begin
        div_start = 1'b1;
        div_num   = 33'(dabs);
        div_den   = 24'(bs_eff);
      end
      default: ;
    endcase
  end

  assign ln_start = (state_q == ST_P_DW) && div_done && need_ln;
  assign out_load = gout_q && (!ov_q || m_axis_tready_i);

  smce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  smce_ln u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ln_start),
    .p_i     (div_quo[16:0]),
    .nl_o    (ln_val),
    .done_o  (ln_done)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      gout_q     <= 1'b0;
      cnt_q      <= '0;
      j_q        <= '0;
      max_q      <= 16'sh8000;
      loss_sum_q <= '0;
      rows_q     <= '0;
      ov_q       <= 1'b0;
      label_q    <= '0;
      soft_q     <= 1'b0;
      sum_q      <= '0;
      acc_q      <= '0;
      done_q     <= 1'b0;
      bad_q      <= 1'b0;
    end else begin
      // gradient word handoff to the output register
      if (out_load) begin
        ov_q   <= 1'b1;
        gout_q <= 1'b0;
        j_q    <= j_q + 1'b1;
        if (last_j) begin
          cnt_q <= '0;
          max_q <= 16'sh8000;
          if (done_q) begin
            loss_sum_q <= '0;
            rows_q     <= '0;
          end
          state_q <= ST_LOAD;
        end else begin
          state_q <= ST_G_RD;
        end
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: if (in_acc) begin
          if (row_we) begin
            cnt_q <= cnt_q + 1'b1;
            if (in_logit > max_q) max_q <= in_logit;
          end
          if (s_axis_tlast_i) begin
            label_q <= s_axis_tdata_i[38:33];
            soft_q  <= mode_q;
            j_q     <= '0;
            sum_q   <= '0;
            acc_q   <= '0;
            state_q <= ST_E_RD;
          end
        end
        ST_E_RD:  state_q <= ST_E_MUL;
        ST_E_MUL: state_q <= ST_E_INT;
        ST_E_INT: state_q <= ST_E_WR;
        ST_E_WR: begin
          sum_q <= sum_q + SUM_W'(ex_val);
          if (last_j) begin
            j_q     <= '0;
            state_q <= ST_P_RD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_E_RD;
          end
        end
        ST_P_RD:  state_q <= ST_P_DIV;
        ST_P_DIV: state_q <= ST_P_DW;
        ST_P_DW: if (div_done) begin
          if (need_ln) begin
            state_q <= ST_P_LW;
          end else if (last_j) begin
            j_q     <= '0;
            state_q <= ST_B_SUM;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_P_RD;
          end
        end
        ST_P_LW: if (ln_done) state_q <= ST_P_ACC;
        ST_P_ACC: begin
          acc_q <= acc_q + 32'(lp_q >> 16);
          if (last_j) begin
            j_q     <= '0;
            state_q <= ST_B_SUM;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_P_RD;
          end
        end
        ST_B_SUM: begin
          loss_sum_q <= ls_sum[32] ? 32'hFFFF_FFFF : ls_sum[31:0];
          rows_q     <= rows_q + 1'b1;
          bad_q      <= !soft_q && ({1'b0, label_q} >= 7'(cnt_q));
          state_q    <= ST_B_DIV;
        end
        ST_B_DIV: begin
          done_q  <= (rows_q >= bs_eff);
          state_q <= ST_B_DW;
        end
        ST_B_DW:  if (div_done) state_q <= ST_G_RD;
        ST_G_RD:  state_q <= ST_G_DIV;
        ST_G_DIV: state_q <= ST_G_DW;
        ST_G_DW: if (div_done) begin
          gout_q  <= 1'b1;
          state_q <= ST_LOAD;  // parked; gout_q holds input off until handoff
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_E_MUL: prod_q <= 33'(tdiff[15:0]) * 33'(LOG2E_Q16);
      ST_E_INT: begin
        k_q    <= u[24:16];
        base_q <= tab_lo;
        ip_q   <= 22'(tab_lo - tab_hi) * 22'(u[10:0]);
      end
      ST_P_DW:  tgl_q <= soft_q ? tg_row : ONE_Q16;
      ST_P_LW:  if (ln_done) lp_q <= 37'(tgl_q) * 37'(ln_val);
      ST_B_SUM: rl_q <= rl_new;
      ST_B_DW:  if (div_done) bl_q <= (div_quo > 33'(LOSS_MAX)) ? LOSS_MAX : div_quo[20:0];
      ST_G_DIV: neg_q <= dval[17];
      ST_G_DW:  if (div_done) g_q <= neg_q ? 18'(-div_quo[17:0]) : div_quo[17:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      odata_q     <= {4'd0, bad_q, done_q, bl_q, rl_q, g_q, 6'(j_q)};
      olast_out_q <= last_j;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_CLASSES)) else $error("element count past row limit");
  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P_RD) |-> sum_q != '0) else $error("exp sum is zero");
  a_row_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_j) |=> (cnt_q == '0) && (state_q == ST_LOAD))
    else $error("row not closed after last gradient word");
endmodule
